>>> rtl/cpa_pkg.sv
// shared types and constants of the compacting pool allocator
package cpa_pkg;

  localparam int unsigned SLOTS_DEF      = 64;
  localparam int unsigned POOL_BYTES_DEF = 65536;

  // beat field widths
  localparam int unsigned SIZE_W   = 17;
  localparam int unsigned HANDLE_W = 6;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned FREE_W   = 17;
  localparam int unsigned SRC_W    = 17;
  localparam int unsigned DST_W    = 16;
  localparam int unsigned LEN_W    = 17;

  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 96;
  localparam int unsigned M_USER_W = 3;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_NO_SLOT  = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_SCAN,
    ST_A_CHK,
    ST_A_BUMP,
    ST_F_CHK,
    ST_F_RD,
    ST_F_SRC,
    ST_F_LEN,
    ST_F_BUMP,
    ST_F_POOL,
    ST_F_WALK,
    ST_DONE
  } state_e;

endpackage

>>> rtl/cpa_ram.sv
// generic simple dual port ram with registered read
module cpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cpa_alu.sv
// shared add / subtract unit with borrow out
module cpa_alu
  import cpa_pkg::*;
#(
  parameter int unsigned W = 17
) (
  input  alu_op_e      op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] res_o,
  output logic         borrow_o
);

  logic [W:0] sum;

  always_comb begin
    if (op_i == ALU_SUB) begin
      sum = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      sum = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  // borrow only means something for a subtract
  assign res_o    = sum[W-1:0];
  assign borrow_o = (op_i == ALU_SUB) && sum[W];

endmodule

>>> rtl/compacting_pool_allocator_core.sv
// top level: sequencer, slot tables and result register of the pool allocator
// A request beat either allocates a block (lowest free slot, placed at the bump
// offset) or frees one, after which every block above the freed one slides down
// by the freed size and at most one move descriptor tells an external mover what bytes to copy.
// The block takes one request at a time. An allocate scans up to the lowest free
// slot; a free walks over the offset table, which issues one read per cycle and
// adjusts one slot per cycle through the single shared adder; a refused free and
// the free of a zero-size block skip the walk. Each result sits in an output
// register, so a new request is taken while the previous result still waits
// for m_axis_tready.
// Offset and length tables are rams whose entries are only used once written.
module compacting_pool_allocator_core
  import cpa_pkg::*;
#(
  parameter int unsigned SLOTS      = SLOTS_DEF,
  parameter int unsigned POOL_BYTES = POOL_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request side
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // alloc_size[16:0], handle[22:17], pad
  input  logic                s_axis_tuser,  // req_type
  // result side
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,  // granted_slot, block_offset, bytes_free,
                                             // move_source, move_dest, move_length, pad
  output logic [M_USER_W-1:0] m_axis_tuser   // status[1:0], move_valid[2]
);

  // pool arithmetic width: offsets and lengths up to the pool size
  localparam int unsigned PW  = $clog2(POOL_BYTES + 1);
  // adder width also covers the full request size field
  localparam int unsigned AW  = (PW > SIZE_W) ? PW : SIZE_W;
  localparam int unsigned SW  = $clog2(SLOTS);
  localparam int unsigned HCW = ((SW > HANDLE_W) ? SW : HANDLE_W) + 1;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  state_e              state_q, state_d;
  logic [AW-1:0]       size_q, size_d;
  logic [HANDLE_W-1:0] hdl_q, hdl_d;
  logic [SW-1:0]       idx_q, idx_d;
  logic                iss_done_q, iss_done_d;
  logic                pend_v_q, pend_v_d;
  logic [SW-1:0]       pend_idx_q, pend_idx_d;
  logic [PW-1:0]       base_q, base_d;
  logic [AW-1:0]       src_q, src_d;
  logic [AW-1:0]       len_q, len_d;
  logic [AW-1:0]       bump_q, bump_d;
  logic [AW-1:0]       pool_q, pool_d;
  logic [SLOTS-1:0]    used_q, used_d;
  status_e             stat_q, stat_d;
  logic [HANDLE_W-1:0] res_slot_q, res_slot_d;
  logic [OFF_W-1:0]    res_off_q, res_off_d;

  logic                m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0] m_data_q, m_data_d;
  logic [M_USER_W-1:0] m_user_q, m_user_d;

  // shared adder
  alu_op_e       alu_op;
  logic [AW-1:0] alu_a, alu_b, alu_res;
  logic          alu_borrow;

  // slot tables
  logic          off_we, len_we;
  logic [SW-1:0] off_waddr, off_raddr, hdl_idx;
  logic [PW-1:0] off_wdata, off_rdata, len_wdata, len_rdata;

  logic s_hs;
  logic hdl_ok;
  logic out_free;
  logic has_move;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign hdl_idx       = SW'(hdl_q);
  assign hdl_ok        = (HCW'(hdl_q) < HCW'(SLOTS)) && used_q[hdl_idx];
  assign out_free      = !m_valid_q || m_axis_tready;
  assign has_move      = (len_q != '0);

  cpa_alu #(.W(AW)) u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  cpa_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (off_waddr),
    .wdata_i (off_wdata),
    .raddr_i (off_raddr),
    .rdata_o (off_rdata)
  );

  // length table is written on allocate and read only at the freed handle
  cpa_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (idx_q),
    .wdata_i (len_wdata),
    .raddr_i (hdl_idx),
    .rdata_o (len_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          state_d = (req_e'(s_axis_tuser) == REQ_ALLOC) ? ST_A_SCAN : ST_F_CHK;
        end
      end
      ST_A_SCAN: begin
        if (!used_q[idx_q]) begin
          state_d = ST_A_CHK;
        end else if (idx_q == LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_A_CHK:  state_d = alu_borrow ? ST_DONE : ST_A_BUMP;
      ST_A_BUMP: state_d = ST_DONE;
      ST_F_CHK:  state_d = hdl_ok ? ST_F_RD : ST_DONE;
      ST_F_RD:   state_d = (len_rdata == '0) ? ST_DONE : ST_F_SRC;
      ST_F_SRC:  state_d = ST_F_LEN;
      ST_F_LEN:  state_d = ST_F_BUMP;
      ST_F_BUMP: state_d = ST_F_POOL;
      ST_F_POOL: state_d = ST_F_WALK;
      ST_F_WALK: begin
        if (pend_v_q && (pend_idx_q == LAST)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    size_d     = size_q;
    hdl_d      = hdl_q;
    idx_d      = idx_q;
    iss_done_d = iss_done_q;
    pend_v_d   = 1'b0;
    pend_idx_d = pend_idx_q;
    base_d     = base_q;
    src_d      = src_q;
    len_d      = len_q;
    bump_d     = bump_q;
    pool_d     = pool_q;
    used_d     = used_q;
    stat_d     = stat_q;
    res_slot_d = res_slot_q;
    res_off_d  = res_off_q;

    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;

    off_we    = 1'b0;
    len_we    = 1'b0;
    off_waddr = idx_q;
    off_wdata = PW'(bump_q);
    len_wdata = PW'(size_q);
    off_raddr = (state_q == ST_F_WALK) ? idx_q : hdl_idx;

    m_valid_d = m_axis_tready ? 1'b0 : m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          size_d     = AW'(s_axis_tdata[SIZE_W-1:0]);
          hdl_d      = s_axis_tdata[SIZE_W +: HANDLE_W];
          idx_d      = '0;
          len_d      = '0;
          res_slot_d = '0;
          res_off_d  = '0;
        end
      end
      ST_A_SCAN: begin
        if (used_q[idx_q]) begin
          if (idx_q == LAST) begin
            stat_d = STAT_NO_SLOT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_A_CHK: begin
        // idx_q holds the lowest free slot
        alu_op = ALU_SUB;
        alu_a  = pool_q;
        alu_b  = size_q;
        if (alu_borrow) begin
          stat_d = STAT_NO_SPACE;
        end else begin
          pool_d         = alu_res;
          used_d[idx_q]  = 1'b1;
          off_we         = 1'b1;
          len_we         = 1'b1;
          stat_d         = STAT_OK;
          res_slot_d     = HANDLE_W'(idx_q);
          res_off_d      = OFF_W'(bump_q);
        end
      end
      ST_A_BUMP: begin
        alu_op = ALU_ADD;
        alu_a  = bump_q;
        alu_b  = size_q;
        bump_d = alu_res;
      end
      ST_F_CHK: begin
        if (!hdl_ok) begin
          stat_d = STAT_EMPTY;
        end
      end
      ST_F_RD: begin
        // zero-size blocks just release their slot
        base_d          = off_rdata;
        size_d          = AW'(len_rdata);
        used_d[hdl_idx] = 1'b0;
        stat_d          = STAT_OK;
      end
      ST_F_SRC: begin
        alu_op = ALU_ADD;
        alu_a  = AW'(base_q);
        alu_b  = size_q;
        src_d  = alu_res;
      end
      ST_F_LEN: begin
        alu_op = ALU_SUB;
        alu_a  = bump_q;
        alu_b  = src_q;
        len_d  = alu_borrow ? '0 : alu_res;
      end
      ST_F_BUMP: begin
        alu_op = ALU_SUB;
        alu_a  = bump_q;
        alu_b  = size_q;
        bump_d = alu_borrow ? '0 : alu_res;
      end
      ST_F_POOL: begin
        alu_op     = ALU_ADD;
        alu_a      = pool_q;
        alu_b      = size_q;
        pool_d     = alu_res;
        idx_d      = '0;
        iss_done_d = 1'b0;
      end
      ST_F_WALK: begin
        // read slot idx_q while adjusting the slot whose read was issued in the previous cycle
        if (!iss_done_q) begin
          pend_v_d   = 1'b1;
          pend_idx_d = idx_q;
          if (idx_q == LAST) begin
            iss_done_d = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        alu_op    = ALU_SUB;
        alu_a     = AW'(off_rdata);
        alu_b     = size_q;
        off_waddr = pend_idx_q;
        off_wdata = alu_borrow ? '0 : PW'(alu_res);
        off_we    = pend_v_q && used_q[pend_idx_q] && (off_rdata > base_q);
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = {has_move, stat_q};
          m_data_d  = {
            {(M_DATA_W - LEN_W - DST_W - SRC_W - FREE_W - OFF_W - HANDLE_W){1'b0}},
            has_move ? LEN_W'(len_q) : {LEN_W{1'b0}},
            has_move ? DST_W'(base_q) : {DST_W{1'b0}},
            has_move ? SRC_W'(src_q) : {SRC_W{1'b0}},
            FREE_W'(pool_q),
            res_off_q,
            res_slot_q
          };
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      iss_done_q <= 1'b0;
      pend_v_q   <= 1'b0;
      bump_q     <= '0;
      pool_q     <= AW'(POOL_BYTES);
      used_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      iss_done_q <= iss_done_d;
      pend_v_q   <= pend_v_d;
      bump_q     <= bump_d;
      pool_q     <= pool_d;
      used_q     <= used_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    hdl_q      <= hdl_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    base_q     <= base_d;
    src_q      <= src_d;
    len_q      <= len_d;
    stat_q     <= stat_d;
    res_slot_q <= res_slot_d;
    res_off_q  <= res_off_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

>>> rtl/cpa_checker.sv
// port-level checks of the pool allocator, bound to the top level
module cpa_checker
  import cpa_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata,
  input logic [M_USER_W-1:0] m_axis_tuser
);

  // one request at a time: ready drops right after a request beat
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // a move descriptor only comes with a successful status
  a_move_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == STAT_OK)
    else $error("move descriptor on a refused request");

  a_refused_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] != STAT_OK) |->
      !m_axis_tuser[2] && (m_axis_tdata[21:0] == '0) && (m_axis_tdata[88:39] == '0))
    else $error("refused request carries slot, offset or move fields");

endmodule

bind compacting_pool_allocator_core cpa_checker u_cpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> test/tb_compacting_pool_allocator_core.sv
// self-checking testbench of the compacting pool allocator core
module tb_compacting_pool_allocator_core;
  import cpa_pkg::*;

  localparam int unsigned SLOTS        = SLOTS_DEF;
  localparam int unsigned POOL_BYTES   = POOL_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1330;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned PHASE_LEN    = 190;
  // percent of allocate requests per random phase, starting alloc-heavy
  // so that the slot table runs out early
  localparam int unsigned ALLOC_BIAS [7] = '{95, 50, 25, 70, 95, 40, 60};

  typedef struct packed {
    status_e            status;
    logic [5:0]         slot;
    logic [OFF_W-1:0]   offset;
    logic [FREE_W-1:0]  free;
    logic               mv;
    logic [SRC_W-1:0]   src;
    logic [DST_W-1:0]   dst;
    logic [LEN_W-1:0]   len;
  } reply_t;

  typedef struct {
    req_e                req;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
    bit                  typed;
    reply_t              want;
  } plan_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [M_USER_W-1:0] m_axis_tuser;

  // shadow copy of the allocator state
  bit          slot_taken [SLOTS];
  int unsigned slot_base  [SLOTS];
  int unsigned slot_size  [SLOTS];
  int unsigned bump_ptr   = 0;
  int unsigned bytes_left = POOL_BYTES;

  reply_t      awaited_replies [$];
  int unsigned mismatch_count = 0;
  int unsigned sent_count     = 0;
  int unsigned replies_seen   = 0;

  compacting_pool_allocator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // applies one request to the shadow state and returns the reply it yields
  function automatic reply_t predict_reply(req_e req, logic [SIZE_W-1:0] size,
                                           logic [HANDLE_W-1:0] h);
    reply_t      r;
    int          pick;
    int unsigned base;
    int unsigned sz;
    int unsigned src;
    int unsigned run;
    r = '0;
    r.status = STAT_OK;
    if (req == REQ_ALLOC) begin
      pick = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_taken[i]) pick = i;
      end
      if (pick < 0) begin
        r.status = STAT_NO_SLOT;
      end else if (size > bytes_left) begin
        r.status = STAT_NO_SPACE;
      end else begin
        slot_taken[pick] = 1'b1;
        slot_base[pick]  = bump_ptr;
        slot_size[pick]  = size;
        r.slot   = pick[5:0];
        r.offset = bump_ptr[OFF_W-1:0];  // full pool shows offset 0
        bump_ptr   += size;
        bytes_left -= size;
      end
    end else if (!slot_taken[h]) begin
      r.status = STAT_EMPTY;
    end else begin
      base = slot_base[h];
      sz   = slot_size[h];
      slot_taken[h] = 1'b0;
      if (sz != 0) begin
        // slide every higher block down by the freed size
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_taken[i] && slot_base[i] > base) begin
            slot_base[i] = (slot_base[i] >= sz) ? slot_base[i] - sz : 0;
          end
        end
        src = base + sz;
        run = (bump_ptr > src) ? bump_ptr - src : 0;
        bump_ptr   = (bump_ptr >= sz) ? bump_ptr - sz : 0;
        bytes_left += sz;
        if (run != 0) begin
          r.mv  = 1'b1;
          r.src = src[SRC_W-1:0];
          r.dst = base[DST_W-1:0];
          r.len = run[LEN_W-1:0];
        end
      end
    end
    r.free = bytes_left[FREE_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t row(req_e req, int unsigned size, int unsigned h, bit typed,
                                    status_e st, int unsigned slot, int unsigned off,
                                    int unsigned free);
    plan_row_t p;
    p.req         = req;
    p.size        = size[SIZE_W-1:0];
    p.handle      = h[HANDLE_W-1:0];
    p.typed       = typed;
    p.want        = '0;
    p.want.status = st;
    p.want.slot   = slot[5:0];
    p.want.offset = off[OFF_W-1:0];
    p.want.free   = free[FREE_W-1:0];
    return p;
  endfunction

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t reply %0d: %s expected 0x%0h got 0x%0h",
               $time, replies_seen, what, want, got);
    end
  endtask

  // one request beat; idle cycles before it unless in the calm stretch
  task automatic offer_request(req_e req, logic [SIZE_W-1:0] size,
                               logic [HANDLE_W-1:0] h, bit typed, reply_t want);
    reply_t guess;
    bit     calm;
    calm = (sent_count >= 700 && sent_count < 900);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {1'b0, h, size};
    do @(posedge clk_i); while (!s_axis_tready);
    guess = predict_reply(req, size, h);
    awaited_replies.push_back(typed ? want : guess);
    sent_count++;
  endtask

  // hold the request side low until every reply is back
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited_replies.size() != 0);
  endtask

  // request side: directed table, then random phases
  initial begin : request_side
    plan_row_t   plan [$];
    int unsigned roll;
    int unsigned bias;
    int unsigned start;
    req_e        req;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] h;

    for (int i = 0; i < SLOTS; i++) begin
      slot_taken[i] = 1'b0;
      slot_base[i]  = 0;
      slot_size[i]  = 0;
    end

    // empty slots and oversize requests on a fresh pool
    plan.push_back(row(REQ_FREE,  0,      0,  1, STAT_EMPTY,    0, 0, 65536));
    plan.push_back(row(REQ_FREE,  0,      63, 1, STAT_EMPTY,    0, 0, 65536));
    plan.push_back(row(REQ_ALLOC, 131071, 63, 1, STAT_NO_SPACE, 0, 0, 65536));
    plan.push_back(row(REQ_ALLOC, 65537,  0,  1, STAT_NO_SPACE, 0, 0, 65536));
    // zero-size block, then three real ones
    plan.push_back(row(REQ_ALLOC, 0,      0,  1, STAT_OK,       0, 0, 65536));
    plan.push_back(row(REQ_ALLOC, 100,    0,  0, STAT_OK,       0, 0, 0));
    plan.push_back(row(REQ_ALLOC, 200,    0,  0, STAT_OK,       0, 0, 0));
    plan.push_back(row(REQ_ALLOC, 300,    0,  0, STAT_OK,       0, 0, 0));
    // free from the bottom moves the rest down
    plan.push_back(row(REQ_FREE,  0,      1,  0, STAT_OK,       0, 0, 0));
    // freeing the zero-size block clears its slot
    plan.push_back(row(REQ_FREE,  0,      0,  0, STAT_OK,       0, 0, 0));
    // top block: nothing above it to move
    plan.push_back(row(REQ_FREE,  0,      3,  0, STAT_OK,       0, 0, 0));
    plan.push_back(row(REQ_FREE,  0,      3,  1, STAT_EMPTY,    0, 0, 65336));
    // fill the pool exactly, then zero-size at the very end
    plan.push_back(row(REQ_ALLOC, 65336,  0,  0, STAT_OK,       0, 0, 0));
    plan.push_back(row(REQ_ALLOC, 0,      0,  0, STAT_OK,       0, 0, 0));
    plan.push_back(row(REQ_ALLOC, 1,      0,  1, STAT_NO_SPACE, 0, 0, 0));
    // largest move
    plan.push_back(row(REQ_FREE,  0,      2,  0, STAT_OK,       0, 0, 0));
    plan.push_back(row(REQ_FREE,  0,      0,  0, STAT_OK,       0, 0, 0));
    plan.push_back(row(REQ_FREE,  0,      1,  0, STAT_OK,       0, 0, 0));
    // whole pool as one block, source lands on the pool end
    plan.push_back(row(REQ_ALLOC, 65536,  42, 0, STAT_OK,       0, 0, 0));
    plan.push_back(row(REQ_FREE,  0,      0,  0, STAT_OK,       0, 0, 0));
    plan.push_back(row(REQ_ALLOC, 'h15555, 21, 1, STAT_NO_SPACE, 0, 0, 65536));
    plan.push_back(row(REQ_FREE,  'h0AAAA, 42, 1, STAT_EMPTY,   0, 0, 65536));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      offer_request(plan[i].req, plan[i].size, plan[i].handle, plan[i].typed,
                    plan[i].want);
    end
    drain_replies();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 1100) drain_replies();
      bias = ALLOC_BIAS[(k / PHASE_LEN) % 7];
      h    = HANDLE_W'($urandom_range(0, 63));
      size = SIZE_W'($urandom_range(0, 131071));
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // raw noise over the whole field space
        req = req_e'($urandom_range(0, 1));
      end else if ($urandom_range(0, 99) < bias) begin
        req  = REQ_ALLOC;
        roll = $urandom_range(0, 99);
        if (roll < 55)      size = SIZE_W'($urandom_range(1, 512));
        else if (roll < 65) size = '0;
        else if (roll < 75) size = SIZE_W'($urandom_range(1, 8192));
        else if (roll < 82) size = bytes_left[SIZE_W-1:0];
        else if (roll < 88) size = bytes_left[SIZE_W-1:0] + 1'b1;
      end else begin
        req = REQ_FREE;
        // mostly a live handle, sometimes whatever comes
        if ($urandom_range(0, 9) != 0) begin
          start = $urandom_range(0, SLOTS - 1);
          for (int j = SLOTS - 1; j >= 0; j--) begin
            if (slot_taken[(start + j) % SLOTS]) h = HANDLE_W'((start + j) % SLOTS);
          end
        end
      end
      offer_request(req, size, h, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: check each beat, random back-pressure plus one long hold-off
  initial begin : result_side
    reply_t      want;
    int unsigned holdoff_left;
    bit          held;
    holdoff_left = 0;
    held         = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (awaited_replies.size() == 0) begin
          flag_mismatch("beat with no request pending", 0, 0);
        end else begin
          want = awaited_replies.pop_front();
          if (m_axis_tuser[1:0] !== want.status)
            flag_mismatch("status", want.status, m_axis_tuser[1:0]);
          if (m_axis_tdata[5:0] !== want.slot)
            flag_mismatch("granted_slot", want.slot, m_axis_tdata[5:0]);
          if (m_axis_tdata[21:6] !== want.offset)
            flag_mismatch("block_offset", want.offset, m_axis_tdata[21:6]);
          if (m_axis_tdata[38:22] !== want.free)
            flag_mismatch("bytes_free", want.free, m_axis_tdata[38:22]);
          if (m_axis_tuser[2] !== want.mv)
            flag_mismatch("move_valid", want.mv, m_axis_tuser[2]);
          if (m_axis_tdata[55:39] !== want.src)
            flag_mismatch("move_source", want.src, m_axis_tdata[55:39]);
          if (m_axis_tdata[71:56] !== want.dst)
            flag_mismatch("move_dest", want.dst, m_axis_tdata[71:56]);
          if (m_axis_tdata[88:72] !== want.len)
            flag_mismatch("move_length", want.len, m_axis_tdata[88:72]);
        end
        replies_seen++;
      end
      if (!held && replies_seen == 350) begin
        held         = 1'b1;
        holdoff_left = 600;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else if (replies_seen >= 700 && replies_seen < 900) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

endmodule
